// File: rtl/core/odd_harmonic_additive_oscillator_unit_defines.svh
// Assertion macros shared by the oscillator RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef ODD_HARMONIC_ADDITIVE_OSCILLATOR_UNIT_DEFINES_SVH
`define ODD_HARMONIC_ADDITIVE_OSCILLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OHAO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define OHAO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ohao_pkg.sv
// Shared constants, types and elaboration-time tables for the oscillator.
// No dependencies; imported by every module of the block.
`default_nettype none
package ohao_pkg;

  localparam int HARMONIC_COUNT   = 6;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int PACKED_SLOTS     = 6;
  localparam int HARM_W           = $clog2(2 * HARMONIC_COUNT);
  localparam int LANE_IDX_W       = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;

  localparam int MAG_W       = 52;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = MAG_W / DIV_BITS;
  localparam int SUM_W       = MAG_W + LANE_IDX_W + 1;
  localparam int SCALED_W    = SUM_W + 3;
  localparam int QUO_W       = SCALED_W - 32;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HGAINS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGAINS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 3'd5;

  localparam int EXP_FRAC_W = 12;

  localparam logic [31:0] SINE_C9 = 32'd172272;
  localparam logic [31:0] SINE_COEF [4] = '{32'd5026993, 32'd85569306,
                                            32'd693598668, 32'd1686629713};

  typedef logic [31:0] root_tab_t [EXP_FRAC_W];

  typedef struct packed {
    logic [31:0]        phase;
    logic [HARM_W-1:0]  harm;
    logic signed [9:0]  gain;
    logic [8:0]         igain;
    logic signed [15:0] modv;
    logic               conn;
  } lane_req_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_tab_t make_roots();
    root_tab_t   t;
    logic [63:0] r;
    r = isqrt64(64'h8000_0000_0000_0000);
    t[EXP_FRAC_W-1] = r[31:0];
    for (int i = EXP_FRAC_W - 1; i > 0; i--) begin
      r = isqrt64({r[32:0], 31'd0});
      t[i-1] = r[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = make_roots();

endpackage
`default_nettype wire

// File: rtl/core/ohao_exp2.sv
// Pitch-to-increment unit: clamps the pitch and forms base * 2^pitch.
// Uses ohao_pkg for the root table; one 32x32 multiply per cycle.
`default_nettype none
module ohao_exp2 import ohao_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] pitch,
  input  wire logic signed [3:0]  octave,
  input  wire logic [31:0]        base_inc,
  output logic                    done,
  output logic [31:0]             incr
);

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_ROOT  = 2'd1;
  localparam logic [1:0] E_SCALE = 2'd2;
  localparam logic [1:0] E_SHIFT = 2'd3;

  logic [1:0]  state_r;
  logic [3:0]  cnt_r;
  logic [15:0] q_r, q_nxt;
  logic [31:0] acc_r;
  logic [63:0] prod_r, root_p;
  logic [31:0] incr_r;
  logic        done_r;
  logic signed [17:0] psum, pclamp;
  logic [5:0]  shamt;
  logic [63:0] shifted;

  always_comb begin
    psum = $signed({{2{pitch[15]}}, pitch}) + $signed({{2{octave[3]}}, octave, 12'd0});
    if (psum > 18'sd16384) pclamp = 18'sd16384;
    else if (psum < -18'sd16384) pclamp = -18'sd16384;
    else pclamp = psum;
    q_nxt   = 16'(pclamp + 18'sd16384);
    root_p  = 64'(acc_r) * 64'(ROOT_TAB[cnt_r]);
    shamt   = 6'd35 - {2'd0, q_r[15:12]};
    shifted = prod_r >> shamt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        E_IDLE: begin
          if (start) begin
            q_r     <= q_nxt;
            acc_r   <= 32'h8000_0000;
            cnt_r   <= '0;
            state_r <= E_ROOT;
          end
        end
        E_ROOT: begin
          if (q_r[cnt_r]) acc_r <= root_p[62:31];
          if (cnt_r == 4'(EXP_FRAC_W - 1)) state_r <= E_SCALE;
          cnt_r <= cnt_r + 4'd1;
        end
        E_SCALE: begin
          prod_r  <= 64'(base_inc) * 64'(acc_r);
          state_r <= E_SHIFT;
        end
        E_SHIFT: begin
          incr_r  <= shifted[31:0];
          done_r  <= 1'b1;
          state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign incr = incr_r;

endmodule
`default_nettype wire

// File: rtl/core/ohao_lane.sv
// One harmonic lane: sine of h*phase, gain and modulation, division by h.
// Uses ohao_pkg for the polynomial coefficients and the request type.
`default_nettype none
module ohao_lane import ohao_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire lane_req_t               req,
  output logic                         done,
  output logic signed [MAG_W-1:0]      term
);

  localparam logic [3:0] L_IDLE = 4'd0;
  localparam logic [3:0] L_Z    = 4'd1;
  localparam logic [3:0] L_SQ   = 4'd2;
  localparam logic [3:0] L_HORN = 4'd3;
  localparam logic [3:0] L_FIN  = 4'd4;
  localparam logic [3:0] L_G1   = 4'd5;
  localparam logic [3:0] L_G2   = 4'd6;
  localparam logic [3:0] L_ABS  = 4'd7;
  localparam logic [3:0] L_DIV  = 4'd8;
  localparam logic [3:0] L_SIGN = 4'd9;

  logic [3:0]  state_r, cnt_r;
  lane_req_t   req_r;
  logic [30:0] z_r;
  logic        qneg_r, tneg_r, done_r;
  logic [31:0] z2_r, p_r;
  logic signed [16:0] s_r;
  logic signed [27:0] a_r;
  logic signed [25:0] fac_r;
  logic signed [MAG_W-1:0] prod_r, term_r;
  logic [MAG_W-1:0] qm_r, qm_nxt;
  logic [HARM_W-1:0] rem_r, rem_nxt;

  logic [31:0] turn, xv, mul_a, mul_b;
  logic [SINE_IDX_W-1:0] idx;
  logic [29:0] rv;
  logic [63:0] mul_p;
  logic [15:0] vmag;
  logic signed [10:0] gsum;
  logic signed [25:0] igm;
  logic signed [53:0] full_p;

  always_comb begin
    turn  = 32'(req_r.phase * 32'(req_r.harm));
    idx   = turn[31 -: SINE_IDX_W];
    xv    = {idx, {(32 - SINE_IDX_W){1'b0}}};
    rv    = xv[29:0];
    mul_a = {1'b0, z_r};
    mul_b = {1'b0, z_r};
    case (state_r)
      L_HORN: begin
        mul_a = z2_r;
        mul_b = p_r;
      end
      L_FIN: mul_b = p_r;
      default: ;
    endcase
    mul_p  = 64'(mul_a) * 64'(mul_b);
    vmag   = mul_p[60:45];
    gsum   = 11'sd128 + $signed({req_r.gain[9], req_r.gain});
    igm    = $signed({1'b0, req_r.igain}) * req_r.modv;
    full_p = a_r * fac_r;
  end

  always_comb begin
    logic [HARM_W:0] rw;
    rem_nxt = rem_r;
    qm_nxt  = qm_r;
    for (int b = 0; b < DIV_BITS; b++) begin
      rw     = {rem_nxt, qm_nxt[MAG_W-1]};
      qm_nxt = {qm_nxt[MAG_W-2:0], 1'b0};
      if (rw >= {1'b0, req_r.harm}) begin
        rw        = rw - {1'b0, req_r.harm};
        qm_nxt[0] = 1'b1;
      end
      rem_nxt = rw[HARM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        L_IDLE: begin
          if (start) begin
            req_r   <= req;
            state_r <= L_Z;
          end
        end
        L_Z: begin
          qneg_r  <= xv[31];
          z_r     <= xv[30] ? (31'h4000_0000 - {1'b0, rv}) : {1'b0, rv};
          state_r <= L_SQ;
        end
        L_SQ: begin
          z2_r    <= mul_p[61:30];
          p_r     <= SINE_C9;
          cnt_r   <= '0;
          state_r <= L_HORN;
        end
        L_HORN: begin
          p_r   <= SINE_COEF[cnt_r[1:0]] - mul_p[61:30];
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd3) state_r <= L_FIN;
        end
        L_FIN: begin
          s_r     <= qneg_r ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
          state_r <= L_G1;
        end
        L_G1: begin
          a_r     <= gsum * s_r;
          fac_r   <= req_r.conn ? (26'sd4194304 + igm) : 26'sd4194304;
          state_r <= L_G2;
        end
        L_G2: begin
          prod_r  <= full_p[MAG_W-1:0];
          state_r <= L_ABS;
        end
        L_ABS: begin
          tneg_r  <= prod_r[MAG_W-1];
          qm_r    <= prod_r[MAG_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= L_DIV;
        end
        L_DIV: begin
          qm_r  <= qm_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(DIV_STEPS - 1)) state_r <= L_SIGN;
        end
        L_SIGN: begin
          term_r  <= tneg_r ? -$signed(qm_r) : $signed(qm_r);
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign term = term_r;

endmodule
`default_nettype wire

// File: rtl/core/ohao_merge.sv
// Merging stage: accumulates lane terms, scales by 5/2^32 and clamps.
// Uses ohao_pkg for widths; walks the lanes one per cycle.
`default_nettype none
module ohao_merge import ohao_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [MAG_W-1:0] terms [HARMONIC_COUNT],
  input  wire logic [15:0]             cap,
  output logic                         done,
  output logic signed [16:0]           audio
);

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_SUM   = 2'd1;
  localparam logic [1:0] M_SCALE = 2'd2;
  localparam logic [1:0] M_CLAMP = 2'd3;

  logic [1:0]                state_r;
  logic [LANE_IDX_W-1:0]     idx_r;
  logic signed [SUM_W-1:0]   acc_r;
  logic signed [QUO_W-1:0]   quo_r;
  logic signed [16:0]        audio_r;
  logic                      done_r;
  logic signed [SCALED_W-1:0] scaled, biased;
  logic signed [QUO_W-1:0]   capp;

  always_comb begin
    scaled = ($signed(SCALED_W'(acc_r)) <<< 2) + SCALED_W'(acc_r);
    biased = scaled + (scaled[SCALED_W-1] ? SCALED_W'(33'h0_FFFF_FFFF) : '0);
    capp   = $signed(QUO_W'({1'b0, cap}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            acc_r   <= '0;
            idx_r   <= '0;
            state_r <= M_SUM;
          end
        end
        M_SUM: begin
          acc_r <= acc_r + SUM_W'(terms[idx_r]);
          idx_r <= idx_r + 1'b1;
          if (idx_r == LANE_IDX_W'(HARMONIC_COUNT - 1)) state_r <= M_SCALE;
        end
        M_SCALE: begin
          quo_r   <= biased[SCALED_W-1:32];
          state_r <= M_CLAMP;
        end
        M_CLAMP: begin
          if (quo_r > capp) audio_r <= 17'(capp);
          else if (quo_r < -capp) audio_r <= 17'(-capp);
          else audio_r <= 17'(quo_r);
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign audio = audio_r;

endmodule
`default_nettype wire

// File: rtl/core/odd_harmonic_additive_oscillator_unit.sv
// Top level of the odd-harmonic additive oscillator: registers, phases, control.
// Depends on ohao_pkg, ohao_exp2, ohao_lane, ohao_merge and the defines header.
//
// Each request on the in_ channel is one audio sample tick carrying a pitch
// voltage, six modulation voltages and a connection mask. Each request yields
// exactly one result on the out_ channel: the clamped waveform sample and the
// blink light. Requests are handled one at a time: the pitch unit makes
// twelve root multiplies on one multiplier, the six harmonic lanes run side
// by side (sine polynomial, gain products and a 4-bit-per-cycle division by
// the harmonic number), and then the merging stage runs. A new request is
// not taken until the previous result is loaded into the output register.
// Configuration writes on the cfg_ channel are always accepted; the user must
// make them only while no request is in flight, as the block itself does not
// enforce this. The result sits in an output register, so the next request
// is accepted while a result still waits; when the receiver stalls, the
// finished sample holds inside the block until the output register frees.
// Reset loads the register defaults and clears both phases.
`default_nettype none
`include "odd_harmonic_additive_oscillator_unit_defines.svh"
module odd_harmonic_additive_oscillator_unit import ohao_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    in_pitch_cv,
  input  wire logic signed [15:0]    in_mod_one,
  input  wire logic signed [15:0]    in_mod_three,
  input  wire logic signed [15:0]    in_mod_five,
  input  wire logic signed [15:0]    in_mod_seven,
  input  wire logic signed [15:0]    in_mod_nine,
  input  wire logic signed [15:0]    in_mod_eleven,
  input  wire logic [5:0]            in_mod_connected,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [16:0]         out_audio_out,
  output logic                       out_blink_light,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXP    = 3'd1;
  localparam logic [2:0] ST_LSTART = 3'd2;
  localparam logic [2:0] ST_LANE   = 3'd3;
  localparam logic [2:0] ST_MERGE  = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]         state_r;
  logic signed [3:0]  octave_offset_r;
  logic [15:0]        cap_level_r;
  logic [59:0]        harmonic_gains_r;
  logic [53:0]        input_gains_r;
  logic [31:0]        base_increment_r, blink_increment_r;
  logic [31:0]        osc_phase_r, blink_phase_r;
  logic signed [15:0] mod_r [PACKED_SLOTS];
  logic [PACKED_SLOTS-1:0] conn_r;
  logic               out_valid_r, out_blink_r;
  logic signed [16:0] out_audio_r;

  logic               in_acc, exp_done, merge_done, out_load;
  logic [31:0]        exp_incr;
  lane_req_t          lane_req [HARMONIC_COUNT];
  logic [HARMONIC_COUNT-1:0] lane_done;
  logic signed [MAG_W-1:0]   lane_term [HARMONIC_COUNT];
  logic signed [16:0] merge_audio;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_offset_r   <= '0;
      cap_level_r       <= 16'd40960;
      harmonic_gains_r  <= '0;
      input_gains_r     <= '0;
      base_increment_r  <= 32'd23409800;
      blink_increment_r <= 32'd89478;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OCTAVE:   octave_offset_r   <= cfg_data[3:0];
        CFG_CAP:      cap_level_r       <= cfg_data[15:0];
        CFG_HGAINS:   harmonic_gains_r  <= cfg_data[59:0];
        CFG_IGAINS:   input_gains_r     <= cfg_data[53:0];
        CFG_BASE_INC: base_increment_r  <= cfg_data[31:0];
        CFG_BLINK:    blink_increment_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mod_r[0] <= in_mod_one;
      mod_r[1] <= in_mod_three;
      mod_r[2] <= in_mod_five;
      mod_r[3] <= in_mod_seven;
      mod_r[4] <= in_mod_nine;
      mod_r[5] <= in_mod_eleven;
      conn_r   <= in_mod_connected;
    end
    if (out_load) begin
      out_audio_r <= merge_audio;
      out_blink_r <= ~blink_phase_r[31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      osc_phase_r   <= '0;
      blink_phase_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_acc) state_r <= ST_EXP;
        ST_EXP: begin
          if (exp_done) begin
            osc_phase_r   <= osc_phase_r + exp_incr;
            blink_phase_r <= blink_phase_r + blink_increment_r;
            state_r       <= ST_LSTART;
          end
        end
        ST_LSTART: state_r <= ST_LANE;
        ST_LANE:   if (lane_done[0]) state_r <= ST_MERGE;
        ST_MERGE:  if (merge_done) state_r <= ST_OUT;
        ST_OUT:    if (out_load) state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  ohao_exp2 u_exp2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .pitch    (in_pitch_cv),
    .octave   (octave_offset_r),
    .base_inc (base_increment_r),
    .done     (exp_done),
    .incr     (exp_incr)
  );

  for (genvar k = 0; k < HARMONIC_COUNT; k++) begin : g_lane
    assign lane_req[k].phase = osc_phase_r;
    assign lane_req[k].harm  = HARM_W'(2 * k + 1);
    if (k < PACKED_SLOTS) begin : g_packed
      assign lane_req[k].gain  = harmonic_gains_r[10*k +: 10];
      assign lane_req[k].igain = input_gains_r[9*k +: 9];
      assign lane_req[k].modv  = mod_r[k];
      assign lane_req[k].conn  = conn_r[k];
    end else begin : g_plain
      assign lane_req[k].gain  = '0;
      assign lane_req[k].igain = '0;
      assign lane_req[k].modv  = '0;
      assign lane_req[k].conn  = 1'b0;
    end
    ohao_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (state_r == ST_LSTART),
      .req   (lane_req[k]),
      .done  (lane_done[k]),
      .term  (lane_term[k])
    );
  end

  ohao_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == ST_LANE) && lane_done[0]),
    .terms (lane_term),
    .cap   (cap_level_r),
    .done  (merge_done),
    .audio (merge_audio)
  );

  assign out_valid       = out_valid_r;
  assign out_audio_out   = out_audio_r;
  assign out_blink_light = out_blink_r;

  `OHAO_ASSERT_IMP(a_exp_done_state, exp_done, state_r == ST_EXP, "increment ready outside pitch phase")
  `OHAO_ASSERT_IMP(a_lanes_together, lane_done[0], &lane_done, "harmonic lanes finished apart")
  `OHAO_ASSERT_IMP(a_merge_done_state, merge_done, state_r == ST_MERGE, "merge result out of sequence")
  `OHAO_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_r == ST_EXP, "request not started")

endmodule
`default_nettype wire
